/* hdl/bdbp_pkg.sv */
// ----------------------------------------------------------------------------
// bdbp_pkg
// Types and constants shared by the branch displacement backpatcher modules.
// ----------------------------------------------------------------------------
package bdbp_pkg;

  // Result limit per input word, and the width of a counter that holds it.
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // The byte buffer and the label space match the field widths, so
  // addresses wrap at 16 bits and labels compare on all 8 bits.
  localparam int BUFFER_BYTES = 65536;
  localparam int LABEL_COUNT  = 256;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_RANGE = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_DEFINE = 1'b1;

  localparam logic KIND_REL8  = 1'b0;
  localparam logic KIND_REL32 = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  label_id;
    logic [15:0] position;
    logic        fix_kind;
  } in_item_t;

  typedef struct packed {
    logic [15:0] byte_addr;
    logic [7:0]  byte_value;
    logic [1:0]  error_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  label;
    logic [15:0] site;
    logic        kind;
  } fixup_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD,
    ST_FULL,
    ST_RD,
    ST_EVAL,
    ST_FIX,
    ST_EMIT,
    ST_REPLACE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic add;
    logic err_full;
    logic rd;
    logic skip;
    logic start_fix;
    logic emit;
    logic replace;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic is_define;
    logic full;
    logic scan_end;
    logic match;
    logic last_byte;
  } dp_status_t;

endpackage

/* hdl/bdbp_ctrl.sv */
// ----------------------------------------------------------------------------
// bdbp_ctrl
// Sequencer for adds, table-full errors and the define scan.
// ----------------------------------------------------------------------------
module bdbp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bdbp_pkg::dp_status_t  status,
  output bdbp_pkg::dp_cmd_t     cmd
);

  bdbp_pkg::state_t state_r;
  bdbp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdbp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdbp_pkg::ST_IDLE: begin
        if (start) state_nxt = bdbp_pkg::ST_DISPATCH;
      end
      bdbp_pkg::ST_DISPATCH: begin
        if (status.is_define)  state_nxt = bdbp_pkg::ST_RD;
        else if (status.full)  state_nxt = bdbp_pkg::ST_FULL;
        else                   state_nxt = bdbp_pkg::ST_ADD;
      end
      bdbp_pkg::ST_ADD:     state_nxt = bdbp_pkg::ST_IDLE;
      bdbp_pkg::ST_FULL:    state_nxt = bdbp_pkg::ST_IDLE;
      bdbp_pkg::ST_RD: begin
        state_nxt = status.scan_end ? bdbp_pkg::ST_FLUSH : bdbp_pkg::ST_EVAL;
      end
      bdbp_pkg::ST_EVAL: begin
        state_nxt = status.match ? bdbp_pkg::ST_FIX : bdbp_pkg::ST_RD;
      end
      bdbp_pkg::ST_FIX:     state_nxt = bdbp_pkg::ST_EMIT;
      bdbp_pkg::ST_EMIT: begin
        if (status.last_byte) state_nxt = bdbp_pkg::ST_REPLACE;
      end
      bdbp_pkg::ST_REPLACE: state_nxt = bdbp_pkg::ST_RD;
      bdbp_pkg::ST_FLUSH:   state_nxt = bdbp_pkg::ST_IDLE;
      default:              state_nxt = bdbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      bdbp_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      bdbp_pkg::ST_DISPATCH: ;
      bdbp_pkg::ST_ADD:     cmd.add       = 1'b1;
      bdbp_pkg::ST_FULL:    cmd.err_full  = 1'b1;
      bdbp_pkg::ST_RD:      cmd.rd        = 1'b1;
      bdbp_pkg::ST_EVAL:    cmd.skip      = !status.match;
      bdbp_pkg::ST_FIX:     cmd.start_fix = 1'b1;
      bdbp_pkg::ST_EMIT:    cmd.emit      = 1'b1;
      bdbp_pkg::ST_REPLACE: cmd.replace   = 1'b1;
      bdbp_pkg::ST_FLUSH:   cmd.flush     = 1'b1;
      default: ;
    endcase
  end

endmodule

/* hdl/bdbp_datapath.sv */
// ----------------------------------------------------------------------------
// bdbp_datapath
// Fixup table memory, scan index, displacement arithmetic and result register.
// ----------------------------------------------------------------------------
module bdbp_datapath #(
  parameter int FIXUP_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bdbp_pkg::in_item_t    in_item,
  input  bdbp_pkg::dp_cmd_t     cmd,
  output bdbp_pkg::dp_status_t  status,
  output logic                  out_strobe,
  output bdbp_pkg::out_item_t   out_item
);

  localparam int IDXW = (FIXUP_SLOTS > 1) ? $clog2(FIXUP_SLOTS) : 1;
  localparam int CNTW = $clog2(FIXUP_SLOTS + 1);
  localparam int RCW  = bdbp_pkg::RES_CNT_W;

  bdbp_pkg::fixup_t mem [FIXUP_SLOTS];

  bdbp_pkg::in_item_t   item_r;
  bdbp_pkg::fixup_t     rd_a_r;
  bdbp_pkg::fixup_t     rd_b_r;
  logic [CNTW-1:0]      count_r;
  logic [CNTW-1:0]      idx_r;
  logic [RCW-1:0]       res_cnt_r;
  logic [1:0]           k_r;
  logic signed [17:0]   disp_r;
  logic                 range_err_r;
  bdbp_pkg::out_item_t  pend_r;
  logic                 pend_v_r;
  logic                 out_strobe_r;
  bdbp_pkg::out_item_t  out_r;

  logic [CNTW-1:0]      last_idx;
  logic signed [17:0]   disp_nxt;
  logic [31:0]          disp32;
  bdbp_pkg::out_item_t  new_res;
  logic                 can_emit;

  assign last_idx = count_r - CNTW'(1);

  // Both offsets fit an 18-bit signed difference; rel32 bytes come from its
  // sign extension.
  assign disp_nxt = $signed({2'b00, item_r.position}) - $signed({2'b00, rd_a_r.site})
                  - ((rd_a_r.kind == bdbp_pkg::KIND_REL32) ? 18'sd4 : 18'sd1);
  assign disp32   = {{14{disp_r[17]}}, disp_r};

  always_comb begin
    new_res.byte_addr  = rd_a_r.site + {14'd0, k_r};
    new_res.byte_value = 8'(disp32 >> {k_r, 3'b000});
    new_res.error_code = bdbp_pkg::ERR_NONE;
    new_res.last       = 1'b0;
    if (rd_a_r.kind == bdbp_pkg::KIND_REL8 && range_err_r) begin
      new_res.byte_value = 8'd0;
      new_res.error_code = bdbp_pkg::ERR_RANGE;
    end
  end

  assign can_emit = res_cnt_r < RCW'(bdbp_pkg::MAX_RESULTS);

  assign status.is_define = (item_r.cmd == bdbp_pkg::CMD_DEFINE);
  assign status.full      = (count_r >= CNTW'(FIXUP_SLOTS));
  assign status.scan_end  = (idx_r >= count_r);
  assign status.match     = (rd_a_r.label == item_r.label_id);
  assign status.last_byte = (rd_a_r.kind == bdbp_pkg::KIND_REL8) || (k_r == 2'd3);

  // Table memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      mem[count_r[IDXW-1:0]] <= '{label: item_r.label_id, site: item_r.position,
                                  kind: item_r.fix_kind};
    end else if (cmd.replace) begin
      mem[idx_r[IDXW-1:0]] <= rd_b_r;
    end
    if (cmd.rd) begin
      rd_a_r <= mem[idx_r[IDXW-1:0]];
      rd_b_r <= mem[last_idx[IDXW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.start_fix) begin
      disp_r      <= disp_nxt;
      range_err_r <= (disp_nxt < -18'sd128) || (disp_nxt > 18'sd127);
    end
    if (cmd.emit && can_emit) pend_r <= new_res;
    if (cmd.err_full) begin
      out_r <= '{byte_addr: 16'd0, byte_value: 8'd0,
                 error_code: bdbp_pkg::ERR_FULL, last: 1'b1};
    end else if (cmd.emit && can_emit && pend_v_r) begin
      out_r <= pend_r;
    end else if (cmd.flush && pend_v_r) begin
      out_r <= '{byte_addr: pend_r.byte_addr, byte_value: pend_r.byte_value,
                 error_code: pend_r.error_code, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      idx_r        <= '0;
      res_cnt_r    <= '0;
      k_r          <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.err_full || (cmd.emit && can_emit && pend_v_r)
                   || (cmd.flush && pend_v_r);
      if (cmd.load) begin
        idx_r     <= '0;
        res_cnt_r <= '0;
        pend_v_r  <= 1'b0;
      end
      if (cmd.add)       count_r <= count_r + CNTW'(1);
      if (cmd.replace)   count_r <= last_idx;
      if (cmd.skip)      idx_r   <= idx_r + CNTW'(1);
      if (cmd.start_fix) k_r     <= '0;
      if (cmd.emit) begin
        k_r <= k_r + 2'd1;
        if (can_emit) begin
          res_cnt_r <= res_cnt_r + RCW'(1);
          pend_v_r  <= 1'b1;
        end
      end
      if (cmd.flush) pend_v_r <= 1'b0;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(FIXUP_SLOTS))
    else $error("fixup count above table size");

  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.error_code == bdbp_pkg::ERR_FULL |-> out_r.last)
    else $error("table-full error not marked last");

  a_replace_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.replace |=> count_r == $past(count_r) - CNTW'(1))
    else $error("resolved fixup did not shrink the table");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.error_code == bdbp_pkg::ERR_RANGE |-> out_r.byte_value == 8'd0)
    else $error("range error carries a nonzero byte");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> !pend_v_r)
    else $error("pending result survived the end of a scan");

endmodule

/* hdl/branch_displacement_backpatcher_top.sv */
// ----------------------------------------------------------------------------
// branch_displacement_backpatcher_top
// Pending branch fixup table that emits displacement byte writes on define.
// ----------------------------------------------------------------------------
// One word is taken while busy is low and start is high; busy stays high
// until the last result of that word sits in the output register, and that
// result is strobed in the first cycle with busy low. A define examines the
// table entries in turn and, for each match, emits its displacement bytes,
// one for rel8 and four for rel32; a resolved slot is refilled from the last
// entry and examined again.
// Results appear one per cycle at most, each for one cycle with out_strobe,
// and cannot be held off, so the receiver must take every strobed word.
// ----------------------------------------------------------------------------
module branch_displacement_backpatcher_top #(
  parameter int FIXUP_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bdbp_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output bdbp_pkg::out_item_t  out_item
);

  bdbp_pkg::dp_cmd_t    cmd;
  bdbp_pkg::dp_status_t status;

  bdbp_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  bdbp_datapath #(
    .FIXUP_SLOTS (FIXUP_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
